// ----- rtl/i2cm_pkg.sv -----
package i2cm_pkg;

  // Command codes carried by the kind field. The four commands share their
  // encoding with the operation that they start.
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic [15:0] UNIT_TICKS_RST = 16'd96;

  // Phases within one segment group and the bit count of a byte transfer.
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LAST  = 2'd2;
  localparam logic [3:0] ACK_BIT  = 4'd8;
  localparam logic [3:0] NUM_BITS = 4'd9;

  typedef struct packed {
    op_e        op;
    logic [1:0] phase;
    logic [3:0] bit_index;
    logic [1:0] units_left;
    logic [7:0] shift_reg;
    logic       scl;
    logic       sda;
    logic       drv;
    logic       ack_flag;
    logic       ack_to_send;
    logic [7:0] last_read;
  } eng_state_t;

  localparam eng_state_t ENG_STATE_RST = '{
    op:          OP_IDLE,
    phase:       2'd0,
    bit_index:   4'd0,
    units_left:  2'd0,
    shift_reg:   8'd0,
    scl:         1'b1,
    sda:         1'b1,
    drv:         1'b1,
    ack_flag:    1'b0,
    ack_to_send: 1'b0,
    last_read:   8'd0
  };

  // Status produced alongside the next engine state.
  typedef struct packed {
    logic done;
    logic rej;
  } eng_status_t;

endpackage

// ----- rtl/i2cm_step.sv -----
module i2cm_step (
  input  i2cm_pkg::eng_state_t  cur_i,
  input  logic [2:0]            kind_i,
  input  logic [7:0]            write_data_i,
  input  logic                  send_ack_i,
  input  logic                  sda_in_i,
  input  logic                  unit_end_i,
  output i2cm_pkg::eng_state_t  nxt_o,
  output i2cm_pkg::eng_status_t status_o
);

  // Sets the lines and the unit count at the start of the current segment.
  function automatic i2cm_pkg::eng_state_t seg_begin(input i2cm_pkg::eng_state_t s);
    i2cm_pkg::eng_state_t r;
    r = s;
    unique case (s.op)
      i2cm_pkg::OP_START: begin
        if (s.phase == i2cm_pkg::PH_SETUP) begin
          r.scl = 1'b1; r.sda = 1'b1; r.drv = 1'b1; r.units_left = 2'd2;
        end else if (s.phase == i2cm_pkg::PH_HIGH) begin
          r.sda = 1'b0; r.units_left = 2'd2;
        end else begin
          r.scl = 1'b0; r.units_left = 2'd1;
        end
      end
      i2cm_pkg::OP_STOP: begin
        if (s.phase == i2cm_pkg::PH_SETUP) begin
          r.sda = 1'b0; r.drv = 1'b1; r.units_left = 2'd1;
        end else if (s.phase == i2cm_pkg::PH_HIGH) begin
          r.scl = 1'b1; r.units_left = 2'd2;
        end else begin
          r.sda = 1'b1; r.units_left = 2'd2;
        end
      end
      i2cm_pkg::OP_WRITE: begin
        if (s.phase == i2cm_pkg::PH_SETUP) begin
          if (s.bit_index < i2cm_pkg::ACK_BIT) begin
            r.drv = 1'b1; r.sda = s.shift_reg[7];
          end else begin
            r.drv = 1'b0; r.sda = 1'b1;
          end
          r.units_left = 2'd1;
        end else if (s.phase == i2cm_pkg::PH_HIGH) begin
          r.scl = 1'b1;
          if (s.bit_index < i2cm_pkg::ACK_BIT) begin
            r.shift_reg = {s.shift_reg[6:0], 1'b0};
          end
          r.units_left = 2'd2;
        end else begin
          r.scl = 1'b0; r.units_left = 2'd1;
        end
      end
      i2cm_pkg::OP_READ: begin
        if (s.phase == i2cm_pkg::PH_SETUP) begin
          if (s.bit_index < i2cm_pkg::ACK_BIT) begin
            r.drv = 1'b0;
          end else begin
            r.drv = 1'b1; r.sda = ~s.ack_to_send;
          end
          r.units_left = 2'd1;
        end else if (s.phase == i2cm_pkg::PH_HIGH) begin
          r.scl = 1'b1; r.units_left = 2'd2;
        end else begin
          r.scl = 1'b0; r.units_left = 2'd1;
        end
      end
      default: begin
        r.units_left = 2'd0;
      end
    endcase
    return r;
  endfunction

  i2cm_pkg::eng_state_t n;
  logic                 finish;
  logic                 is_byte_op;

  always_comb begin
    n          = cur_i;
    finish     = 1'b0;
    is_byte_op = (cur_i.op == i2cm_pkg::OP_WRITE) || (cur_i.op == i2cm_pkg::OP_READ);
    status_o   = '0;
    unique case (kind_i)
      i2cm_pkg::KIND_TICK: begin
        if (cur_i.op != i2cm_pkg::OP_IDLE && unit_end_i) begin
          if (n.units_left != 2'd0) begin
            n.units_left = n.units_left - 2'd1;
          end
          if (n.units_left == 2'd0) begin
            // End of a segment: sample SDA at the end of the SCL-high phase.
            if (n.phase == i2cm_pkg::PH_HIGH) begin
              if (n.op == i2cm_pkg::OP_WRITE && n.bit_index == i2cm_pkg::ACK_BIT) begin
                n.ack_flag = sda_in_i;
              end
              if (n.op == i2cm_pkg::OP_READ && n.bit_index < i2cm_pkg::ACK_BIT) begin
                n.shift_reg = {n.shift_reg[6:0], sda_in_i};
              end
            end
            if (n.phase == i2cm_pkg::PH_LAST) begin
              n.phase = i2cm_pkg::PH_SETUP;
              if (is_byte_op) begin
                n.bit_index = n.bit_index + 4'd1;
                if (n.bit_index < i2cm_pkg::NUM_BITS) begin
                  n = seg_begin(n);
                end else begin
                  finish = 1'b1;
                end
              end else begin
                finish = 1'b1;
              end
            end else begin
              n.phase = n.phase + 2'd1;
              n = seg_begin(n);
            end
            if (finish) begin
              if (n.op == i2cm_pkg::OP_WRITE) begin
                n.drv = 1'b1; n.sda = 1'b1;
              end else if (n.op == i2cm_pkg::OP_READ) begin
                n.last_read = n.shift_reg;
              end
              n.op          = i2cm_pkg::OP_IDLE;
              n.bit_index   = 4'd0;
              n.units_left  = 2'd0;
              status_o.done = 1'b1;
            end
          end
        end
      end
      i2cm_pkg::KIND_START, i2cm_pkg::KIND_STOP,
      i2cm_pkg::KIND_WRITE, i2cm_pkg::KIND_READ: begin
        if (cur_i.op != i2cm_pkg::OP_IDLE) begin
          status_o.rej = 1'b1;
        end else begin
          n.op        = i2cm_pkg::op_e'(kind_i);
          n.phase     = i2cm_pkg::PH_SETUP;
          n.bit_index = 4'd0;
          if (kind_i == i2cm_pkg::KIND_WRITE) begin
            n.shift_reg = write_data_i;
          end
          if (kind_i == i2cm_pkg::KIND_READ) begin
            n.shift_reg   = 8'd0;
            n.ack_to_send = send_ack_i;
          end
          n = seg_begin(n);
        end
      end
      default: begin
        n = cur_i;
      end
    endcase
    nxt_o = n;
  end

endmodule

// ----- rtl/i2c_master_byte_engine_unit.sv -----
// Byte-level I2C master. Each input word is either one time-base tick or one
// command (START, STOP, WRITE byte, READ byte); every accepted word yields
// exactly one result word that reports the SCL/SDA line settings, busy, a
// done pulse on the tick that finishes a command, the last byte read, the
// ACK bit sampled by the last write, and whether the word was a command that
// arrived while busy and was dropped. A delay unit lasts cfg_unit_ticks_i
// ticks (0 behaves as 1, reset value 96); each bit takes one unit with SCL
// low, two units with SCL high (SDA sampled at the end) and one more low.
// Timing: one word per clock cycle sustained, and the result of each accepted
// word is registered in the result register. The whole state update for a word is a
// single pass through the step logic between the engine state registers and
// the result register, and the input is stalled only while a result is held
// by a stalled output. The unit-length register is written through its own
// port, which is always ready; write it only while the engine is idle.
module i2c_master_byte_engine_unit #(
  parameter int PRESCALE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_unit_ticks_i,
  // Input word channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  write_data_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  // Result word channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_level_o,
  output logic        sda_level_o,
  output logic        sda_driven_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_byte_o,
  output logic        nack_seen_o,
  output logic        rejected_o
);

  // Compare width that holds both the tick counter plus one and the unit length.
  localparam int CW = ((PRESCALE_WIDTH > 16) ? PRESCALE_WIDTH : 16) + 1;

  logic [15:0]               unit_ticks_q;
  logic [PRESCALE_WIDTH-1:0] tick_q, tick_d;
  i2cm_pkg::eng_state_t      state_q, state_d;
  i2cm_pkg::eng_status_t     status;

  logic       in_fire;
  logic       busy;
  logic       unit_end;
  logic [CW-1:0] tick_inc;

  logic       out_valid_q, out_valid_d;
  logic       scl_q, sda_q, drv_q, busy_q, done_q, nack_q, rej_q;
  logic [7:0] rbyte_q;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;

  // The input waits only while a finished result is held back downstream.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign busy = (state_q.op != i2cm_pkg::OP_IDLE);

  // A unit ends when the count reaches the configured length or the counter
  // saturates at its own maximum.
  assign tick_inc = CW'(tick_q) + CW'(1);
  assign unit_end = (tick_inc >= CW'(unit_ticks_q)) || (tick_q == '1);

  i2cm_step u_step (
    .cur_i        (state_q),
    .kind_i       (kind_i),
    .write_data_i (write_data_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .unit_end_i   (unit_end),
    .nxt_o        (state_d),
    .status_o     (status)
  );

  // Prescaler: runs only on tick words while busy; a command started from
  // idle restarts it.
  always_comb begin
    tick_d = tick_q;
    case (kind_i) inside
      i2cm_pkg::KIND_TICK: begin
        if (busy) begin
          tick_d = unit_end ? '0 : tick_inc[PRESCALE_WIDTH-1:0];
        end
      end
      i2cm_pkg::KIND_START, i2cm_pkg::KIND_STOP,
      i2cm_pkg::KIND_WRITE, i2cm_pkg::KIND_READ: begin
        if (!busy) begin
          tick_d = '0;
        end
      end
      default: begin
        tick_d = tick_q;
      end
    endcase
  end

  assign out_valid_d = in_fire | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q <= i2cm_pkg::UNIT_TICKS_RST;
      tick_q       <= '0;
      state_q      <= i2cm_pkg::ENG_STATE_RST;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unit_ticks_q <= cfg_unit_ticks_i;
      end
      if (in_fire) begin
        tick_q  <= tick_d;
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result register: captures the state after each accepted word.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      scl_q   <= state_d.scl;
      sda_q   <= state_d.drv ? state_d.sda : 1'b1;
      drv_q   <= state_d.drv;
      busy_q  <= (state_d.op != i2cm_pkg::OP_IDLE);
      done_q  <= status.done;
      rbyte_q <= state_d.last_read;
      nack_q  <= state_d.ack_flag;
      rej_q   <= status.rej;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_level_o  = scl_q;
  assign sda_level_o  = sda_q;
  assign sda_driven_o = drv_q;
  assign busy_res_o   = busy_q;
  assign done_res_o   = done_q;
  assign read_byte_o  = rbyte_q;
  assign nack_seen_o  = nack_q;
  assign rejected_o   = rej_q;

  // An engine that is idle holds no partial bit position or unit count.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (state_q.bit_index == 4'd0) && (state_q.units_left == 2'd0))
    else $error("idle engine holds stale sequencing state");

  // While busy there is always a segment with time left to run.
  a_busy_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (state_q.units_left != 2'd0) && (state_q.bit_index <= i2cm_pkg::ACK_BIT))
    else $error("busy engine without a running segment");

  // A finishing tick leaves the engine idle and is never a rejected command.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && !rejected_o)
    else $error("done reported while still busy or rejected");

  // A rejected command leaves a busy engine busy.
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o)
    else $error("rejection reported while idle");

  // The prescaler does not move while idle.
  a_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !busy && (kind_i == i2cm_pkg::KIND_TICK) |=> $stable(tick_q))
    else $error("prescaler advanced while idle");

endmodule
